// ----- src/wrhm_pkg.sv -----
// Shared constants, register indexes and divider control types for the hour meter.
package wrhm_pkg;

	localparam int CNT_W     = 32;
	localparam int COEFF_W   = 10;
	localparam int COEFF_MAX = (1 << COEFF_W) - 1;
	localparam int LEVELS    = 5;
	localparam int LEVEL_W   = 3;
	localparam int IDX_W     = $clog2(LEVELS);
	localparam int SUM_W     = CNT_W + COEFF_W + $clog2(LEVELS);
	localparam int DIFF_W    = CNT_W + $clog2(LEVELS);
	localparam int CTR_W     = $clog2(SUM_W + 1);
	localparam int DATA_W    = 32;
	localparam int REG_IDX_W = 3;

	localparam logic [REG_IDX_W-1:0] REG_COEFF_NIGHT = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_COEFF_LOW   = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_COEFF_MED   = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_COEFF_HIGH  = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_COEFF_BOOST = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_WEIGHT_DIV  = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_FILTER_LIM  = 3'd6;

	localparam logic [COEFF_W-1:0] COEFF_RST = 10'd100;
	localparam logic [CNT_W-1:0]   LIMIT_RST = 32'd2000;

	localparam logic FUNC_TICK  = 1'b0;
	localparam logic FUNC_CLEAR = 1'b1;

	typedef enum logic [1:0] {
		DIV_SUM = 2'd0,
		DIV_PER = 2'd1,
		DIV_CNT = 2'd2
	} div_op_t;

	typedef struct packed {
		logic    start;
		div_op_t op;
	} div_req_t;

endpackage

// ----- src/wrhm_in_if.sv -----
// Command channel: one beat per tick or clear request.
interface wrhm_in_if;
	import wrhm_pkg::*;

	logic               valid;
	logic               ready;
	logic               func;
	logic [LEVEL_W-1:0] speed_level;

	modport source (output valid, output func, output speed_level, input ready);
	modport sink (input valid, input func, input speed_level, output ready);
endinterface

// ----- src/wrhm_out_if.sv -----
// Result channel: one beat per accepted command.
interface wrhm_out_if;
	import wrhm_pkg::*;

	logic             valid;
	logic             ready;
	logic [CNT_W-1:0] saved_hours;
	logic [CNT_W-1:0] pending_hours;
	logic             warning;
	logic             warning_raised;

	modport source (output valid, output saved_hours, output pending_hours,
		output warning, output warning_raised, input ready);
	modport sink (input valid, input saved_hours, input pending_hours,
		input warning, input warning_raised, output ready);
endinterface

// ----- src/wrhm_div.sv -----
// Shared restoring divider, one quotient bit per cycle, length chosen per operation.
module wrhm_div #(
	parameter int DVS_W = 27
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  wrhm_pkg::div_req_t            req,
	input  logic [wrhm_pkg::SUM_W-1:0]    dividend,
	input  logic [DVS_W-1:0]              divisor,
	output logic                          done,
	output logic [wrhm_pkg::SUM_W-1:0]    quot,
	output logic [DVS_W-1:0]              rem
);
	import wrhm_pkg::*;

	localparam int SHIFT_PER = SUM_W - DVS_W;
	localparam int SHIFT_CNT = SUM_W - CNT_W;

	logic             busy_q;
	logic             done_q;
	logic [CTR_W-1:0] cnt_q;
	logic [SUM_W-1:0] dvd_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;

	logic [SUM_W-1:0] dvd_aligned;
	logic [CTR_W-1:0] nbits;
	logic [DVS_W:0]   trial;
	logic             ge;

	// The dividend is left-aligned so that every operation starts at the top bit.
	always_comb begin
		unique case (req.op)
			DIV_SUM: begin
				dvd_aligned = dividend;
				nbits       = CTR_W'(SUM_W);
			end
			DIV_PER: begin
				dvd_aligned = dividend << SHIFT_PER;
				nbits       = CTR_W'(DVS_W);
			end
			DIV_CNT: begin
				dvd_aligned = dividend << SHIFT_CNT;
				nbits       = CTR_W'(CNT_W);
			end
			default: begin
				dvd_aligned = dividend;
				nbits       = CTR_W'(SUM_W);
			end
		endcase
	end

	assign trial = {rem_q, dvd_q[SUM_W-1]};
	assign ge    = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= nbits;
			end else if (busy_q) begin
				cnt_q <= cnt_q - CTR_W'(1);
				if (cnt_q == CTR_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= dvd_aligned;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[SUM_W-2:0], ge};
			rem_q <= ge ? DVS_W'(trial - {1'b0, dvs_q}) : trial[DVS_W-1:0];
		end
	end

	assign done = done_q;
	assign quot = dvd_q;
	assign rem  = rem_q;
endmodule

// ----- src/wrhm_core.sv -----
// Sequencer, weighted sum accumulator, meter state and result register.
module wrhm_core #(
	parameter int SECONDS_HOUR = 3600,
	parameter int COMMIT_HOURS = 50,
	parameter int DEN_W        = 27
) (
	input  logic                          clk,
	input  logic                          arst_n,
	wrhm_in_if.sink                       cmd,
	wrhm_out_if.source                    res,
	input  logic [wrhm_pkg::COEFF_W-1:0]  coeff [wrhm_pkg::LEVELS],
	input  logic [wrhm_pkg::COEFF_W-1:0]  weight_div,
	input  logic [wrhm_pkg::CNT_W-1:0]    filter_limit,
	output wrhm_pkg::div_req_t            div_req,
	output logic [wrhm_pkg::SUM_W-1:0]    div_dividend,
	output logic [DEN_W-1:0]              div_divisor,
	input  logic                          div_done,
	input  logic [wrhm_pkg::SUM_W-1:0]    div_quot,
	input  logic [DEN_W-1:0]              div_rem
);
	import wrhm_pkg::*;

	localparam int PROD_W = CNT_W + COEFF_W;

	typedef enum logic [3:0] {
		S_IDLE, S_INC, S_MUL, S_ACC, S_DSUM, S_WSUM, S_CPER, S_WPER,
		S_CCNT, S_WCNT, S_CNEXT, S_CSUM, S_WARN, S_DONE
	} state_t;

	state_t            state_q;
	logic [IDX_W-1:0]  idx_q;
	logic [CNT_W-1:0]  cnt_q [LEVELS];
	logic [PROD_W-1:0] prod_q;
	logic [SUM_W-1:0]  acc_q;
	logic [DEN_W-1:0]  denom_q;
	logic [DEN_W-1:0]  period_q;
	logic [DIFF_W-1:0] diff_q;
	logic [CNT_W-1:0]  pending_q;
	logic [CNT_W-1:0]  saved_q;
	logic              warn_q;
	logic              raised_q;
	div_req_t          div_req_q;

	logic              out_valid_q;
	logic [CNT_W-1:0]  out_saved_q;
	logic [CNT_W-1:0]  out_pending_q;
	logic              out_warn_q;
	logic              out_raised_q;

	logic              cmd_beat;
	logic              out_free;
	logic              idx_last;
	logic [CNT_W-1:0]  pend_quot;
	logic [DIFF_W:0]   saved_sum;
	logic [CNT_W:0]    warn_sum;

	assign cmd_beat = cmd.valid && cmd.ready;
	assign out_free = !out_valid_q || res.ready;
	assign idx_last = idx_q == IDX_W'(LEVELS - 1);

	// Quotient of the weighted sum, clamped to the 32-bit result range.
	assign pend_quot = (|div_quot[SUM_W-1:CNT_W]) ? '1 : div_quot[CNT_W-1:0];
	assign saved_sum = (DIFF_W+1)'(saved_q) + (DIFF_W+1)'(diff_q);
	assign warn_sum  = (CNT_W+1)'(saved_q) + (CNT_W+1)'(pending_q);

	always_comb begin
		unique case (div_req_q.op)
			DIV_SUM: begin
				div_dividend = acc_q;
				div_divisor  = denom_q;
			end
			DIV_PER: begin
				div_dividend = SUM_W'(denom_q);
				div_divisor  = DEN_W'(coeff[idx_q]);
			end
			DIV_CNT: begin
				div_dividend = SUM_W'(cnt_q[idx_q]);
				div_divisor  = period_q;
			end
			default: begin
				div_dividend = acc_q;
				div_divisor  = denom_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			for (int i = 0; i < LEVELS; i++) begin
				cnt_q[i] <= '0;
			end
			prod_q        <= '0;
			acc_q         <= '0;
			denom_q       <= '0;
			period_q      <= '0;
			diff_q        <= '0;
			pending_q     <= '0;
			saved_q       <= '0;
			warn_q        <= 1'b0;
			raised_q      <= 1'b0;
			div_req_q     <= '{start: 1'b0, op: DIV_SUM};
			out_valid_q   <= 1'b0;
			out_saved_q   <= '0;
			out_pending_q <= '0;
			out_warn_q    <= 1'b0;
			out_raised_q  <= 1'b0;
		end else begin
			div_req_q.start <= 1'b0;
			if (out_valid_q && res.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd_beat) begin
						raised_q <= 1'b0;
						if (cmd.func == FUNC_CLEAR) begin
							for (int i = 0; i < LEVELS; i++) begin
								cnt_q[i] <= '0;
							end
							pending_q <= '0;
							saved_q   <= '0;
							warn_q    <= 1'b0;
							state_q   <= S_DONE;
						end else begin
							idx_q   <= cmd.speed_level;
							denom_q <= DEN_W'(weight_div) * DEN_W'(SECONDS_HOUR);
							state_q <= S_INC;
						end
					end
				end
				S_INC: begin
					// Levels above boost bump nothing; counters stop at all ones.
					if (idx_q < IDX_W'(LEVELS) && cnt_q[idx_q] != '1) begin
						cnt_q[idx_q] <= cnt_q[idx_q] + CNT_W'(1);
					end
					idx_q   <= '0;
					acc_q   <= '0;
					state_q <= S_MUL;
				end
				S_MUL: begin
					prod_q  <= PROD_W'(cnt_q[idx_q]) * PROD_W'(coeff[idx_q]);
					state_q <= S_ACC;
				end
				S_ACC: begin
					acc_q <= acc_q + SUM_W'(prod_q);
					if (idx_last) begin
						state_q <= S_DSUM;
					end else begin
						idx_q   <= idx_q + IDX_W'(1);
						state_q <= S_MUL;
					end
				end
				S_DSUM: begin
					if (denom_q == '0) begin
						pending_q <= '0;
						state_q   <= S_WARN;
					end else begin
						div_req_q <= '{start: 1'b1, op: DIV_SUM};
						state_q   <= S_WSUM;
					end
				end
				S_WSUM: begin
					if (div_done) begin
						pending_q <= pend_quot;
						if (pend_quot >= CNT_W'(COMMIT_HOURS)) begin
							idx_q   <= '0;
							diff_q  <= '0;
							state_q <= S_CPER;
						end else begin
							state_q <= S_WARN;
						end
					end
				end
				S_CPER: begin
					if (coeff[idx_q] == '0) begin
						state_q <= S_CNEXT;
					end else begin
						div_req_q <= '{start: 1'b1, op: DIV_PER};
						state_q   <= S_WPER;
					end
				end
				S_WPER: begin
					if (div_done) begin
						period_q <= (div_quot == '0) ? DEN_W'(1) : DEN_W'(div_quot);
						state_q  <= S_CCNT;
					end
				end
				S_CCNT: begin
					div_req_q <= '{start: 1'b1, op: DIV_CNT};
					state_q   <= S_WCNT;
				end
				S_WCNT: begin
					if (div_done) begin
						diff_q       <= diff_q + DIFF_W'(div_quot[CNT_W-1:0]);
						cnt_q[idx_q] <= CNT_W'(div_rem);
						state_q      <= S_CNEXT;
					end
				end
				S_CNEXT: begin
					if (idx_last) begin
						state_q <= S_CSUM;
					end else begin
						idx_q   <= idx_q + IDX_W'(1);
						state_q <= S_CPER;
					end
				end
				S_CSUM: begin
					saved_q   <= (|saved_sum[DIFF_W:CNT_W]) ? '1 : saved_sum[CNT_W-1:0];
					pending_q <= (diff_q >= DIFF_W'(pending_q)) ? '0
						: pending_q - diff_q[CNT_W-1:0];
					state_q   <= S_WARN;
				end
				S_WARN: begin
					if (!warn_q && warn_sum >= (CNT_W+1)'(filter_limit)) begin
						warn_q   <= 1'b1;
						raised_q <= 1'b1;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					// A finished beat that is still waiting is never overwritten.
					if (out_free) begin
						out_valid_q   <= 1'b1;
						out_saved_q   <= saved_q;
						out_pending_q <= pending_q;
						out_warn_q    <= warn_q;
						out_raised_q  <= raised_q;
						state_q       <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign cmd.ready          = state_q == S_IDLE;
	assign res.valid          = out_valid_q;
	assign res.saved_hours    = out_saved_q;
	assign res.pending_hours  = out_pending_q;
	assign res.warning        = out_warn_q;
	assign res.warning_raised = out_raised_q;
	assign div_req            = div_req_q;
endmodule

// ----- src/weighted_runtime_hour_meter.sv -----
// Top level of the weighted runtime hour meter: register file, sequencer and divider.
//
// Channel   | Direction | Beat content
// cmd       | in        | func, speed_level
// res       | out       | saved_hours, pending_hours, warning, warning_raised
// wr_*      | in        | wr_en, wr_index, wr_data (plain write, no handshake)
//
// A tick bumps its level counter, then forms the weighted sum and divides it; a
// commit adds two divisions for each level with a nonzero weight, skips a level
// with weight zero and then folds the totals. The single restoring divider serves
// every division, one quotient bit per cycle. arst_n restores the register
// defaults and clears counters, totals and the warning. A finished beat waits in
// the result register; the next command is taken meanwhile and its result waits
// for it.
module weighted_runtime_hour_meter #(
	parameter int SECONDS_HOUR = 3600,
	parameter int COMMIT_HOURS = 50
) (
	input  logic                            clk,
	input  logic                            arst_n,
	wrhm_in_if.sink                         cmd,
	wrhm_out_if.source                      res,
	input  logic                            wr_en,
	input  logic [wrhm_pkg::REG_IDX_W-1:0]  wr_index,
	input  logic [wrhm_pkg::DATA_W-1:0]     wr_data
);
	import wrhm_pkg::*;

	localparam int DEN_W = $clog2(COEFF_MAX * SECONDS_HOUR + 1);

	logic [COEFF_W-1:0] coeff_q [LEVELS];
	logic [COEFF_W-1:0] scale_q;
	logic [CNT_W-1:0]   limit_q;

	div_req_t           div_req;
	logic [SUM_W-1:0]   div_dividend;
	logic [DEN_W-1:0]   div_divisor;
	logic               div_done;
	logic [SUM_W-1:0]   div_quot;
	logic [DEN_W-1:0]   div_rem;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LEVELS; i++) begin
				coeff_q[i] <= COEFF_RST;
			end
			scale_q <= COEFF_RST;
			limit_q <= LIMIT_RST;
		end else if (wr_en) begin
			if (wr_index <= REG_COEFF_BOOST) begin
				coeff_q[IDX_W'(wr_index)] <= wr_data[COEFF_W-1:0];
			end else if (wr_index == REG_WEIGHT_DIV) begin
				scale_q <= wr_data[COEFF_W-1:0];
			end else if (wr_index == REG_FILTER_LIM) begin
				limit_q <= wr_data[CNT_W-1:0];
			end
		end
	end

	wrhm_core #(
		.SECONDS_HOUR (SECONDS_HOUR),
		.COMMIT_HOURS (COMMIT_HOURS),
		.DEN_W        (DEN_W)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.res          (res),
		.coeff        (coeff_q),
		.weight_div   (scale_q),
		.filter_limit (limit_q),
		.div_req      (div_req),
		.div_dividend (div_dividend),
		.div_divisor  (div_divisor),
		.div_done     (div_done),
		.div_quot     (div_quot),
		.div_rem      (div_rem)
	);

	wrhm_div #(
		.DVS_W (DEN_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);
endmodule

// ----- src/wrhm_chk.sv -----
// Port-level checker for the hour meter and the bind that attaches it.
module wrhm_chk (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	input logic cmd_ready,
	input logic cmd_func,
	input logic res_valid,
	input logic res_ready,
	input logic [31:0] res_saved,
	input logic [31:0] res_pending,
	input logic res_warning,
	input logic res_raised
);
	logic       push;
	logic       pop;
	logic [1:0] outst_q;
	logic [1:0] wr_pos;
	logic       func_q [2];

	assign push   = cmd_valid && cmd_ready;
	assign pop    = res_valid && res_ready;
	assign wr_pos = outst_q - 2'(pop);

	// Small queue of the commands whose results are still owed, oldest first.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outst_q   <= '0;
			func_q[0] <= 1'b0;
			func_q[1] <= 1'b0;
		end else begin
			outst_q <= outst_q + 2'(push) - 2'(pop);
			if (pop) begin
				func_q[0] <= func_q[1];
			end
			if (push) begin
				if (wr_pos == 2'd0) begin
					func_q[0] <= cmd_func;
				end else begin
					func_q[1] <= cmd_func;
				end
			end
		end
	end

	a_outst_bound: assert property (@(posedge clk) disable iff (!arst_n)
		outst_q <= 2'd2)
		else $error("more than two commands awaiting results");

	a_no_extra_beat: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> outst_q != 2'd0)
		else $error("result beat without an owed command");

	a_raised_sets_flag: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_raised |-> res_warning)
		else $error("warning raised but flag not set");

	a_clear_zero: assert property (@(posedge clk) disable iff (!arst_n)
		pop && outst_q != 2'd0 && func_q[0] |->
			res_saved == '0 && res_pending == '0 && !res_warning && !res_raised)
		else $error("clear command result not all zero");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result beat withdrawn before it was taken");
endmodule

bind weighted_runtime_hour_meter wrhm_chk u_wrhm_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.cmd_valid   (cmd.valid),
	.cmd_ready   (cmd.ready),
	.cmd_func    (cmd.func),
	.res_valid   (res.valid),
	.res_ready   (res.ready),
	.res_saved   (res.saved_hours),
	.res_pending (res.pending_hours),
	.res_warning (res.warning),
	.res_raised  (res.warning_raised)
);

// ----- bench/tb_top.sv -----
// Self-checking testbench for the weighted runtime hour meter.
module tb_top;
	import wrhm_pkg::*;

	localparam int SECONDS_HOUR = 3600;
	localparam int COMMIT_HOURS = 50;
	localparam int HOLD_CYCLES  = 1000;
	localparam int WATCHDOG     = 12000;
	localparam int DRAIN_CYCLES = 400;

	typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

	typedef struct packed {
		logic [CNT_W-1:0] saved;
		logic [CNT_W-1:0] pending;
		logic             warn;
		logic             raised;
	} reading_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 wr_en;
	logic [REG_IDX_W-1:0] wr_index;
	logic [DATA_W-1:0]    wr_data;

	wrhm_in_if  cmd();
	wrhm_out_if res();

	weighted_runtime_hour_meter #(
		.SECONDS_HOUR(SECONDS_HOUR),
		.COMMIT_HOURS(COMMIT_HOURS)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.res      (res),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	always #1 clk = ~clk;

	// Register copies and meter state of the predictor.
	logic [COEFF_W-1:0] coeff_cfg [LEVELS];
	logic [COEFF_W-1:0] scale_cfg;
	logic [CNT_W-1:0]   limit_cfg;
	logic [CNT_W-1:0]   level_secs [LEVELS];
	logic [CNT_W-1:0]   meter_pending;
	logic [CNT_W-1:0]   meter_saved;
	logic               meter_warn;

	reading_t exp_readings [$];

	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	int unsigned hold_reqs = 0;
	int unsigned hold_served = 0;
	int unsigned hold_left = 0;
	int unsigned quiet_cycles = 0;

	int unsigned n_cmds = 0;
	int unsigned n_results = 0;
	int unsigned n_errors = 0;
	int unsigned n_commits = 0;
	int unsigned n_raised = 0;
	int unsigned n_clears = 0;
	int unsigned n_settings = 0;

	function automatic logic [CNT_W-1:0] clip32(input logic [63:0] v);
		return (v > 64'hFFFF_FFFF) ? '1 : v[CNT_W-1:0];
	endfunction

	// Advances the meter by one command and returns the reading it must report.
	function automatic reading_t meter_step(input logic f, input logic [LEVEL_W-1:0] lvl);
		logic [63:0] denom;
		logic [63:0] wsum;
		logic [63:0] period;
		logic [63:0] moved;
		reading_t    r;
		r.raised = 1'b0;
		if (f == FUNC_CLEAR) begin
			for (int i = 0; i < LEVELS; i++)
				level_secs[i] = '0;
			meter_pending = '0;
			meter_saved = '0;
			meter_warn = 1'b0;
			n_clears++;
		end else begin
			denom = 64'(scale_cfg) * 64'(SECONDS_HOUR);
			if (lvl < LEVELS && level_secs[lvl] != '1)
				level_secs[lvl] = level_secs[lvl] + 1'b1;
			wsum = '0;
			for (int i = 0; i < LEVELS; i++)
				wsum += 64'(level_secs[i]) * 64'(coeff_cfg[i]);
			meter_pending = (denom == 0) ? '0 : clip32(wsum / denom);
			if (denom != 0 && meter_pending >= COMMIT_HOURS) begin
				// Each level with a nonzero weight hands over its whole hours and keeps the leftover seconds.
				moved = '0;
				for (int i = 0; i < LEVELS; i++) begin
					if (coeff_cfg[i] != 0) begin
						period = denom / 64'(coeff_cfg[i]);
						if (period == 0)
							period = 1;
						moved += 64'(level_secs[i]) / period;
						level_secs[i] = CNT_W'(64'(level_secs[i]) % period);
					end
				end
				meter_saved = clip32(64'(meter_saved) + moved);
				meter_pending = (moved >= 64'(meter_pending)) ? '0
					: meter_pending - moved[CNT_W-1:0];
				n_commits++;
			end
			if (!meter_warn && 64'(meter_saved) + 64'(meter_pending) >= 64'(limit_cfg)) begin
				meter_warn = 1'b1;
				r.raised = 1'b1;
				n_raised++;
			end
		end
		r.saved = meter_saved;
		r.pending = meter_pending;
		r.warn = meter_warn;
		return r;
	endfunction

	function automatic logic [LEVELS-1:0][COEFF_W-1:0] rand_weights();
		logic [LEVELS-1:0][COEFF_W-1:0] w;
		for (int i = 0; i < LEVELS; i++) begin
			case ($urandom_range(7))
				0: w[i] = '0;
				1: w[i] = '1;
				2, 3: w[i] = COEFF_W'($urandom_range(1, COEFF_MAX));
				default: w[i] = COEFF_W'($urandom_range(600, COEFF_MAX));
			endcase
		end
		return w;
	endfunction

	task automatic set_idling(input idle_mode_t m);
		case (m)
			IDLE_NONE: begin
				send_idle_pct = 0;
				recv_stall_pct <= 0;
			end
			IDLE_SEND: begin
				send_idle_pct = 49;
				recv_stall_pct <= 0;
			end
			IDLE_RECV: begin
				send_idle_pct = 0;
				recv_stall_pct <= 49;
			end
			default: begin
				send_idle_pct = 7;
				recv_stall_pct <= 7;
			end
		endcase
	endtask

	// Offers one command beat and records its expected reading once accepted.
	task automatic send_cmd(input logic f, input logic [LEVEL_W-1:0] lvl);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd.valid <= 1'b0;
			cmd.func <= 1'($urandom);
			cmd.speed_level <= LEVEL_W'($urandom);
			@(posedge clk);
		end
		cmd.valid <= 1'b1;
		cmd.func <= f;
		cmd.speed_level <= lvl;
		@(posedge clk);
		while (!cmd.ready)
			@(posedge clk);
		exp_readings.push_back(meter_step(f, lvl));
		n_cmds++;
	endtask

	// Drops valid and waits until every reading is back, so the block is idle.
	task automatic wait_idle();
		cmd.valid <= 1'b0;
		while (exp_readings.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Writes all seven registers; narrow registers get junk in their unused bits.
	task automatic load_settings(input logic [LEVELS-1:0][COEFF_W-1:0] weights,
		input logic [COEFF_W-1:0] scale, input logic [CNT_W-1:0] lim);
		logic [DATA_W-1:0]    val;
		logic [REG_IDX_W-1:0] idx;
		for (int r = 0; r <= int'(REG_FILTER_LIM); r++) begin
			idx = REG_IDX_W'(r);
			val = DATA_W'($urandom);
			if (idx == REG_FILTER_LIM)
				val = lim;
			else if (idx == REG_WEIGHT_DIV)
				val[COEFF_W-1:0] = scale;
			else
				val[COEFF_W-1:0] = weights[idx];
			wr_en <= 1'b1;
			wr_index <= idx;
			wr_data <= val;
			@(posedge clk);
			if (idx == REG_FILTER_LIM)
				limit_cfg = val;
			else if (idx == REG_WEIGHT_DIV)
				scale_cfg = val[COEFF_W-1:0];
			else
				coeff_cfg[idx] = val[COEFF_W-1:0];
		end
		wr_en <= 1'b0;
		n_settings++;
	endtask

	// Mostly ticks on the five real levels, some unknown levels, rare clears.
	task automatic run_random(input int n);
		logic                f;
		logic [LEVEL_W-1:0] lvl;
		for (int k = 0; k < n; k++) begin
			f = ($urandom_range(299) == 0) ? FUNC_CLEAR : FUNC_TICK;
			if ($urandom_range(99) < 88)
				lvl = LEVEL_W'($urandom_range(LEVELS - 1));
			else
				lvl = LEVEL_W'($urandom_range(7, LEVELS));
			send_cmd(f, lvl);
		end
	endtask

	task automatic test_directed();
		set_idling(IDLE_NONE);
		// Reset defaults: every level including the uncounted ones, then a clear.
		for (int l = 0; l < 8; l++)
			send_cmd(FUNC_TICK, LEVEL_W'(l));
		send_cmd(FUNC_CLEAR, 3'd7);
		send_cmd(FUNC_TICK, 3'd4);
		wait_idle();
		// Zero scale and zero limit; boost weight is zero.
		load_settings({10'd0, 10'd1023, 10'd1, 10'd500, 10'd1000}, 10'd0, 32'd0);
		send_cmd(FUNC_TICK, 3'd0);
		send_cmd(FUNC_TICK, 3'd4);
		send_cmd(FUNC_TICK, 3'd6);
		send_cmd(FUNC_CLEAR, 3'd0);
		send_cmd(FUNC_TICK, 3'd1);
		wait_idle();
		// Full weights at unit scale and a limit of one hour.
		load_settings({LEVELS{10'd1023}}, 10'd1, 32'd1);
		for (int k = 0; k < 5; k++)
			send_cmd(FUNC_TICK, 3'd4);
		wait_idle();
	endtask

	task automatic test_commit_steady();
		set_idling(IDLE_NONE);
		load_settings({LEVELS{10'd1023}}, 10'd1, 32'd40);
		run_random(420);
		wait_idle();
	endtask

	task automatic test_sender_gaps();
		set_idling(IDLE_SEND);
		load_settings(rand_weights(), 10'd1, $urandom);
		run_random(400);
		wait_idle();
	endtask

	task automatic test_receiver_backpressure();
		set_idling(IDLE_RECV);
		load_settings({LEVELS{10'd1000}}, 10'd2, 32'hFFFF_FFFF);
		// A long hold on the result side fills the block and stalls commands.
		hold_reqs <= hold_reqs + 1;
		run_random(400);
		wait_idle();
	endtask

	task automatic test_both_sides_idle();
		set_idling(IDLE_BOTH);
		// Weight 900 at unit scale makes the period exact, so commits leave hours pending.
		load_settings({LEVELS{10'd900}}, 10'd1, CNT_W'($urandom_range(60, 150)));
		run_random(400);
		wait_idle();
	endtask

	task automatic test_random_settings();
		logic [COEFF_W-1:0] scale;
		logic [CNT_W-1:0]   lim;
		for (int round = 0; round < 4; round++) begin
			set_idling(idle_mode_t'($urandom_range(3)));
			case ($urandom_range(5))
				0: scale = '0;
				1, 2: scale = 10'd1;
				3: scale = 10'd2;
				4: scale = '1;
				default: scale = COEFF_W'($urandom_range(1, COEFF_MAX));
			endcase
			case ($urandom_range(4))
				0: lim = '0;
				1: lim = 32'd1;
				2: lim = CNT_W'($urandom_range(1, 300));
				3: lim = '1;
				default: lim = $urandom;
			endcase
			load_settings(rand_weights(), scale, lim);
			run_random(80);
			wait_idle();
		end
	endtask

	// Result side: random stalls plus an occasional long hold.
	always @(posedge clk) begin
		if (hold_reqs != hold_served) begin
			hold_served <= hold_reqs;
			hold_left <= HOLD_CYCLES;
			res.ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			res.ready <= 1'b0;
		end else begin
			res.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		reading_t want;
		if (res.valid && res.ready) begin
			n_results++;
			if (exp_readings.size() == 0) begin
				$error("result beat with no command outstanding: saved_hours=%0d pending_hours=%0d",
					res.saved_hours, res.pending_hours);
				n_errors++;
			end else begin
				want = exp_readings.pop_front();
				if (res.saved_hours !== want.saved) begin
					$error("saved_hours: expected %0d, got %0d", want.saved, res.saved_hours);
					n_errors++;
				end
				if (res.pending_hours !== want.pending) begin
					$error("pending_hours: expected %0d, got %0d", want.pending, res.pending_hours);
					n_errors++;
				end
				if (res.warning !== want.warn) begin
					$error("warning: expected %0b, got %0b", want.warn, res.warning);
					n_errors++;
				end
				if (res.warning_raised !== want.raised) begin
					$error("warning_raised: expected %0b, got %0b", want.raised, res.warning_raised);
					n_errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((cmd.valid && cmd.ready) || (res.valid && res.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG) begin
			$error("no beat on either channel for %0d cycles, %0d readings outstanding",
				WATCHDOG, exp_readings.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		cmd.valid = 1'b0;
		cmd.func = FUNC_TICK;
		cmd.speed_level = '0;
		res.ready = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		for (int i = 0; i < LEVELS; i++) begin
			coeff_cfg[i] = COEFF_RST;
			level_secs[i] = '0;
		end
		scale_cfg = COEFF_RST;
		limit_cfg = LIMIT_RST;
		meter_pending = '0;
		meter_saved = '0;
		meter_warn = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_commit_steady();
		test_sender_gaps();
		test_receiver_backpressure();
		test_both_sides_idle();
		test_random_settings();

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Ran %0d commands over %0d register settings: %0d clears, %0d commits.",
			n_cmds, n_settings, n_clears, n_commits);
		$display("Warning raised %0d times; %0d result beats checked, %0d mismatches.",
			n_raised, n_results, n_errors);
		if (n_errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
